>>> src/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared sizes, codes and types of the LIFO stack with read cursor.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_TOP    = 3'd2,
    CMD_NEXT   = 3'd3,
    CMD_BOTTOM = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_CURSOR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   value;
    logic [CNT_W-1:0]    count;
  } result_t;

  typedef struct packed {
    logic load;
    logic free;
  } out_ctl_t;

endpackage

>>> src/lsc_cmd_if.sv
// ----------------------------------------------------------------------------
// lsc_cmd_if
// Command channel: valid/ready with command code and push word.
// ----------------------------------------------------------------------------
interface lsc_cmd_if
  import lsc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

>>> src/lsc_res_if.sv
// ----------------------------------------------------------------------------
// lsc_res_if
// Result channel: valid/ready with status, read word and entry count.
// ----------------------------------------------------------------------------
interface lsc_res_if
  import lsc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]  item_count;

  modport source (output valid, output status, output read_value, output item_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input item_count,
                  output ready);
endinterface

>>> src/lsc_ram.sv
// ----------------------------------------------------------------------------
// lsc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/lsc_out_stage.sv
// ----------------------------------------------------------------------------
// lsc_out_stage
// Result register that holds a finished result until the sink takes it.
// ----------------------------------------------------------------------------
module lsc_out_stage
  import lsc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  result_t         res_in,
  output logic            free,
  lsc_res_if.source       result
);

  logic    valid;
  result_t res;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

  assign result.valid      = valid;
  assign result.status     = res.status;
  assign result.read_value = res.value;
  assign result.item_count = res.count;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result loaded over an untaken result");
`endif

endmodule

>>> src/lsc_ctrl.sv
// ----------------------------------------------------------------------------
// lsc_ctrl
// Command sequencer: pointer and cursor state, memory access, result build.
// ----------------------------------------------------------------------------
module lsc_ctrl
  import lsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  lsc_cmd_if.sink           command,
  input  logic              out_free,
  output out_ctl_t          out_ctl,
  output result_t           res,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_addr,
  output logic [DATA_W-1:0] mem_wdata,
  input  logic [DATA_W-1:0] mem_rdata
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [ADDR_W-1:0] cidx, cidx_next;
  logic              cvalid, cvalid_next;
  result_t           res_next;
  logic [CNT_W-1:0]  fill_dec;
  logic [ADDR_W-1:0] cidx_dec;
  logic              accept;

  assign command.ready = (state == ST_IDLE);
  assign accept        = command.valid && command.ready;
  assign fill_dec      = fill - 1'b1;
  assign cidx_dec      = cidx - 1'b1;
  assign mem_wdata     = command.push_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fill   <= '0;
      cidx   <= '0;
      cvalid <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      cidx   <= cidx_next;
      cvalid <= cvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    cidx_next   = cidx;
    cvalid_next = cvalid;
    res_next    = res;
    mem_we      = 1'b0;
    mem_addr    = fill[ADDR_W-1:0];
    out_ctl     = '{load: 1'b0, free: out_free};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_next.status = STAT_OK;
          res_next.value  = '0;
          state_next      = ST_DONE;
          unique case (cmd_t'(command.cmd))
            CMD_PUSH: begin
              if (fill == FILL_MAX) begin
                res_next.status = STAT_FULL;
              end else begin
                mem_we      = 1'b1;
                fill_next   = fill + 1'b1;
                cvalid_next = 1'b0;
              end
            end
            CMD_POP: begin
              cvalid_next = 1'b0;
              if (fill == '0) begin
                res_next.status = STAT_EMPTY;
              end else begin
                fill_next  = fill_dec;
                mem_addr   = fill_dec[ADDR_W-1:0];
                state_next = ST_READ;
              end
            end
            CMD_TOP: begin
              if (fill == '0) begin
                res_next.status = STAT_EMPTY;
              end else begin
                cidx_next   = fill_dec[ADDR_W-1:0];
                cvalid_next = 1'b1;
                mem_addr    = fill_dec[ADDR_W-1:0];
                state_next  = ST_READ;
              end
            end
            CMD_NEXT: begin
              if (!cvalid || cidx == '0 || CNT_W'(cidx) >= fill) begin
                res_next.status = STAT_CURSOR;
              end else begin
                cidx_next  = cidx_dec;
                mem_addr   = cidx_dec;
                state_next = ST_READ;
              end
            end
            CMD_BOTTOM: begin
              if (fill == '0) begin
                res_next.status = STAT_EMPTY;
              end else begin
                cidx_next   = '0;
                cvalid_next = 1'b1;
                mem_addr    = '0;
                state_next  = ST_READ;
              end
            end
            CMD_CLEAR: begin
              fill_next   = '0;
              cvalid_next = 1'b0;
            end
            default: begin
            end
          endcase
          res_next.count = fill_next;
        end
      end
      ST_READ: begin
        res_next.value = mem_rdata;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_ctl.load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("fill count beyond depth");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cvalid |-> (CNT_W'(cidx) < fill))
    else $error("valid cursor points past the top");

  a_read_from_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> ($past(state) == ST_IDLE))
    else $error("memory read without an accepted command");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd_t'(command.cmd) == CMD_PUSH && fill != FILL_MAX)
      |=> (fill == $past(fill) + 1'b1) && !cvalid)
    else $error("accepted push did not advance the fill count");
`endif

endmodule

>>> src/lifo_stack_with_cursor_top.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_cursor_top
// Bounded LIFO stack in a single-port RAM, with a read cursor.
//
// Channels: "command" takes one command per transfer (cmd, push_value);
// "result" returns exactly one transfer per command (status, read_value,
// item_count), in command order.
// Sequencing: push, clear, refused and no-op commands go from the command
// transfer straight to the result being offered; pop and cursor commands
// first pass through the RAM read state. The sequencer handles one command
// at a time and takes no new command until that result is handed on.
// The result register holds one finished result, so the next command is
// taken while that result still waits for the sink.
// Reset: synchronous; empties the stack, invalidates the cursor and drops
// any result in flight. RAM contents are not cleared and need no sweep.
// Stall: while the result register is full and the sink holds ready low,
// the sequencer keeps a second result and stops taking commands.
// ----------------------------------------------------------------------------
module lifo_stack_with_cursor_top
  import lsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lsc_cmd_if.sink   command,
  lsc_res_if.source result
);

  out_ctl_t          out_ctl;
  result_t           res;
  logic              out_free;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  lsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .command   (command),
    .out_free  (out_free),
    .out_ctl   (out_ctl),
    .res       (res),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  lsc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  lsc_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (out_ctl.load),
    .res_in (res),
    .free   (out_free),
    .result (result)
  );

endmodule

>>> tb/lsc_stack_checker.sv
// ----------------------------------------------------------------------------
// lsc_stack_checker
// Watches the command and result channels of the LIFO stack, keeps its own
// copy of the stack, cursor and count, and compares every result transfer
// with the oldest predicted reply. Hands out a mismatch count and the number
// of replies still due.
// ----------------------------------------------------------------------------
module lsc_stack_checker
  import lsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lsc_cmd_if   cmd_mon,
  lsc_res_if   res_mon,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  logic [DATA_W-1:0] stack_mem [DEPTH];
  logic [CNT_W-1:0]  fill_cnt;
  logic [ADDR_W-1:0] cur_idx;
  logic              cur_ok;

  result_t replies_due [$];
  int      errs    = 0;
  int      due_n   = 0;
  int      seen_n  = 0;

  assign fail_count   = errs;
  assign pending      = due_n;
  assign results_seen = seen_n;

  function automatic result_t apply_stack_cmd(input logic [CMD_W-1:0]  op,
                                              input logic [DATA_W-1:0] word);
    result_t r;
    r.status = STAT_OK;
    r.value  = '0;
    case (op)
      CMD_PUSH: begin
        if (fill_cnt == FILL_MAX) begin
          r.status = STAT_FULL;
        end else begin
          stack_mem[fill_cnt[ADDR_W-1:0]] = word;
          fill_cnt = fill_cnt + 1'b1;
          cur_ok   = 1'b0;
        end
      end
      CMD_POP: begin
        cur_ok = 1'b0;
        if (fill_cnt == '0) begin
          r.status = STAT_EMPTY;
        end else begin
          fill_cnt = fill_cnt - 1'b1;
          r.value  = stack_mem[fill_cnt[ADDR_W-1:0]];
        end
      end
      CMD_TOP: begin
        if (fill_cnt == '0) begin
          r.status = STAT_EMPTY;
        end else begin
          cur_idx = ADDR_W'(fill_cnt - 1'b1);
          cur_ok  = 1'b1;
          r.value = stack_mem[cur_idx];
        end
      end
      CMD_NEXT: begin
        if (!cur_ok || cur_idx == '0 || CNT_W'(cur_idx) >= fill_cnt) begin
          r.status = STAT_CURSOR;
        end else begin
          cur_idx = cur_idx - 1'b1;
          r.value = stack_mem[cur_idx];
        end
      end
      CMD_BOTTOM: begin
        if (fill_cnt == '0) begin
          r.status = STAT_EMPTY;
        end else begin
          cur_idx = '0;
          cur_ok  = 1'b1;
          r.value = stack_mem[0];
        end
      end
      CMD_CLEAR: begin
        fill_cnt = '0;
        cur_ok   = 1'b0;
      end
      default: ;
    endcase
    r.count = fill_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      fill_cnt = '0;
      cur_idx  = '0;
      cur_ok   = 1'b0;
      replies_due.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        seen_n++;
        if (replies_due.size() == 0) begin
          $error("result transfer with no command outstanding: status %0d value %h count %0d",
                 res_mon.status, res_mon.read_value, res_mon.item_count);
          errs++;
        end else begin
          want = replies_due.pop_front();
          if (res_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_mon.status);
            errs++;
          end
          if (res_mon.read_value !== want.value) begin
            $error("read_value: expected %h, actual %h", want.value, res_mon.read_value);
            errs++;
          end
          if (res_mon.item_count !== want.count) begin
            $error("item_count: expected %0d, actual %0d", want.count, res_mon.item_count);
            errs++;
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        replies_due.push_back(apply_stack_cmd(cmd_mon.cmd, cmd_mon.push_value));
      end
    end
    due_n = replies_due.size();
  end

endmodule

>>> tb/tb_lifo_stack_with_cursor_top.sv
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_cursor_top
// Drives commands into the LIFO stack: a directed pass over empty, full and
// cursor corner cases, then random command mixes with cursor walks under
// three sender/receiver idle profiles. Results are checked by
// lsc_stack_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_cursor_top;
  import lsc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 70;

  logic clk;
  logic rst;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   cycles;
  int   items_sent;
  int   fail_count;
  int   pending;
  int   results_seen;

  lsc_cmd_if cmd_ch ();
  lsc_res_if res_ch ();

  lifo_stack_with_cursor_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .command (cmd_ch),
    .result  (res_ch)
  );

  lsc_stack_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .cmd_mon      (cmd_ch),
    .res_mon      (res_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ch.ready <= !rst && ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic logic [DATA_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] word);
    while ($urandom_range(99) < snd_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= op;
    cmd_ch.push_value <= word;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // hold off until every reply has been returned
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic random_cmds(input int n);
    int r;
    int k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        send_cmd(CMD_PUSH, rand_word());
      end else if (r < 53) begin
        send_cmd(CMD_POP, rand_word());
      end else if (r < 61) begin
        send_cmd(CMD_TOP, rand_word());
      end else if (r < 76) begin
        send_cmd(CMD_NEXT, rand_word());
      end else if (r < 82) begin
        send_cmd(CMD_BOTTOM, rand_word());
      end else if (r < 85) begin
        send_cmd(CMD_CLEAR, rand_word());
      end else if (r < 87) begin
        send_cmd($urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7, rand_word());
      end else if (r < 88) begin
        wait_drained();
      end else begin
        // cursor walk from the top toward the bottom
        k = $urandom_range(8, 1);
        send_cmd(CMD_TOP, rand_word());
        repeat (k) send_cmd(CMD_NEXT, rand_word());
        i += k;
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    cycles            = 0;
    items_sent        = 0;
    snd_idle_pct      = 19;
    rcv_idle_pct      = 56;
    cmd_ch.valid      = 1'b0;
    cmd_ch.cmd        = CMD_PUSH;
    cmd_ch.push_value = '0;
    res_ch.ready      = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty stack corners and spare codes
    send_cmd(CMD_POP, '1);
    send_cmd(CMD_TOP, '0);
    send_cmd(CMD_BOTTOM, '0);
    send_cmd(CMD_NEXT, '0);
    send_cmd(CMD_CLEAR, '0);
    send_cmd(CMD_SPARE6, '1);
    send_cmd(CMD_SPARE7, '0);
    // small stack, cursor walk to bottom and invalidation
    send_cmd(CMD_PUSH, '0);
    send_cmd(CMD_PUSH, '1);
    send_cmd(CMD_PUSH, 32'hA5A5_5A5A);
    send_cmd(CMD_TOP, '0);
    send_cmd(CMD_NEXT, '0);
    send_cmd(CMD_NEXT, '0);
    send_cmd(CMD_NEXT, '0);
    send_cmd(CMD_BOTTOM, '0);
    send_cmd(CMD_NEXT, '0);
    send_cmd(CMD_TOP, '0);
    send_cmd(CMD_PUSH, 32'h5A5A_A5A5);
    send_cmd(CMD_NEXT, '0);
    send_cmd(CMD_TOP, '0);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_NEXT, '0);
    repeat (4) send_cmd(CMD_POP, '0);
    wait_drained();

    // fill to capacity, refused push keeps the cursor
    repeat (DEPTH) send_cmd(CMD_PUSH, rand_word());
    send_cmd(CMD_PUSH, '1);
    send_cmd(CMD_TOP, '0);
    send_cmd(CMD_PUSH, '0);
    send_cmd(CMD_NEXT, '0);
    send_cmd(CMD_BOTTOM, '0);
    send_cmd(CMD_NEXT, '0);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_PUSH, '1);
    send_cmd(CMD_PUSH, '0);
    send_cmd(CMD_CLEAR, '0);
    send_cmd(CMD_NEXT, '0);
    send_cmd(CMD_POP, '0);
    wait_drained();

    random_cmds(RANDOM_PER_PHASE);
    wait_drained();
    snd_idle_pct = 56;
    rcv_idle_pct = 19;
    random_cmds(RANDOM_PER_PHASE);
    wait_drained();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_cmds(RANDOM_PER_PHASE);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d commands and %0d results: empty and full stack, spare codes,",
             items_sent, results_seen);
    $display("cursor walks to the bottom, and three sender/receiver idle profiles.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
